@@ hdl/wfah_pkg.sv @@
package wfah_pkg;

  typedef logic [63:0] word_t;
  typedef logic [3:0]  count_t;
  typedef logic [31:0] half_t;

  localparam word_t  OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam word_t  FNV_PRIME_LO = 64'h0000_0000_0000_01B3;  // prime = 2^40 + 0x1B3
  localparam int     FNV_PRIME_SH = 40;
  localparam word_t  FMIX_MUL_A   = 64'hFF51_AFD7_ED55_8CCD;
  localparam word_t  FMIX_MUL_B   = 64'hC4CE_B9FE_1A85_EC53;
  localparam int     WORD_SHIFT   = 29;
  localparam int     FMIX_SHIFT   = 33;
  localparam count_t FULL_BYTES   = 4'd8;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAKE,
    OP_TAIL,
    OP_FIN,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAIL,
    ST_FIN,
    ST_MA0,
    ST_MA1,
    ST_MA2,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic sel_b;   // finaliser constant B rather than A
  } cmd_t;

  typedef struct packed {
    logic item_absent;
    logic item_last;
    logic item_tail;   // last word with 1..7 bytes
    logic tail_done;   // one byte left in the tail
    logic out_free;
  } status_t;

  // Multiply by the FNV prime, modulo 2^64: shift plus a 9-bit constant product
  function automatic word_t fnv_mul(input word_t x);
    word_t lo;
    lo = x * FNV_PRIME_LO;
    return (x << FNV_PRIME_SH) + lo;
  endfunction

  function automatic word_t mix_word(input word_t x);
    word_t p;
    p = fnv_mul(x);
    return p ^ (p >> WORD_SHIFT);
  endfunction

endpackage

@@ hdl/wfah_if.sv @@
interface wfah_in_if;
  import wfah_pkg::*;

  logic   valid;
  logic   ready;
  word_t  data_word;
  count_t byte_count;
  logic   last;
  logic   absent;

  modport source (output valid, data_word, byte_count, last, absent, input ready);
  modport sink   (input valid, data_word, byte_count, last, absent, output ready);
endinterface

interface wfah_out_if;
  import wfah_pkg::*;

  logic  valid;
  logic  ready;
  word_t hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

@@ hdl/wfah_datapath.sv @@
module wfah_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfah_pkg::cmd_t      cmd_i,
  output wfah_pkg::status_t   status_o,
  input  wfah_pkg::word_t     data_word_i,
  input  wfah_pkg::count_t    byte_count_i,
  input  logic                last_i,
  input  logic                absent_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wfah_pkg::word_t     hash_value_o
);
  import wfah_pkg::*;

  word_t       acc_q, acc_d;
  word_t       total_q, total_d;
  word_t       word_q, word_d;
  logic [2:0]  cnt_q, cnt_d;
  word_t       v_q, v_d;
  word_t       prod_q, prod_d;
  word_t       res_q, res_d;
  logic        out_valid_q, out_valid_d;

  word_t       fin_x;
  word_t       fin_p;
  word_t       konst;
  half_t       mul_a, mul_b;
  word_t       mul_p;
  logic        full_word;

  assign full_word = !last_i || (byte_count_i >= FULL_BYTES);

  assign status_o.item_absent = absent_i;
  assign status_o.item_last   = last_i;
  assign status_o.item_tail   = last_i && (byte_count_i < FULL_BYTES) && (byte_count_i != '0);
  assign status_o.tail_done   = (cnt_q == 3'd1);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  // Shared 32x32 multiplier for the finaliser's 64-bit products
  assign konst = cmd_i.sel_b ? FMIX_MUL_B : FMIX_MUL_A;
  assign mul_a = (cmd_i.op == OP_MUL_HL) ? v_q[63:32] : v_q[31:0];
  assign mul_b = (cmd_i.op == OP_MUL_LH) ? konst[63:32] : konst[31:0];
  assign mul_p = mul_a * mul_b;

  assign fin_x = acc_q ^ total_q;
  assign fin_p = {prod_q[63:32] + mul_p[31:0], prod_q[31:0]};

  always_comb begin
    acc_d       = acc_q;
    total_d     = total_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    v_d         = v_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (cmd_i.op)
      OP_TAKE: begin
        if (absent_i) begin
          acc_d   = OFFSET_BASIS;
          total_d = '0;
          v_d     = OFFSET_BASIS;
        end else if (full_word) begin
          acc_d   = mix_word(acc_q ^ data_word_i);
          total_d = total_q + 64'(FULL_BYTES);
        end else begin
          word_d  = data_word_i;
          cnt_d   = byte_count_i[2:0];
          total_d = total_q + 64'(byte_count_i);
        end
      end
      OP_TAIL: begin
        acc_d  = fnv_mul(acc_q ^ {56'd0, word_q[7:0]});
        word_d = word_q >> 8;
        cnt_d  = cnt_q - 3'd1;
      end
      OP_FIN: begin
        v_d     = fin_x ^ (fin_x >> FMIX_SHIFT);
        acc_d   = OFFSET_BASIS;
        total_d = '0;
      end
      OP_MUL_LL: prod_d = mul_p;
      OP_MUL_LH: prod_d = {prod_q[63:32] + mul_p[31:0], prod_q[31:0]};
      OP_MUL_HL: v_d = fin_p ^ (fin_p >> FMIX_SHIFT);
      OP_EMIT: begin
        res_d       = v_q;
        out_valid_d = 1'b1;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= OFFSET_BASIS;
      total_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    v_q    <= v_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = res_q;

endmodule

@@ hdl/wfah_ctrl.sv @@
module wfah_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wfah_pkg::status_t  status_i,
  output wfah_pkg::cmd_t     cmd_o
);
  import wfah_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_fire = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (status_i.item_absent)    state_d = ST_EMIT;
          else if (status_i.item_tail) state_d = ST_TAIL;
          else if (status_i.item_last) state_d = ST_FIN;
        end
      end
      ST_TAIL: if (status_i.tail_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_MA0;
      ST_MA0:  state_d = ST_MA1;
      ST_MA1:  state_d = ST_MA2;
      ST_MA2:  state_d = ST_MB0;
      ST_MB0:  state_d = ST_MB1;
      ST_MB1:  state_d = ST_MB2;
      ST_MB2:  state_d = ST_EMIT;
      ST_EMIT: if (status_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.sel_b = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) cmd_o.op = OP_TAKE;
      end
      ST_TAIL: cmd_o.op = OP_TAIL;
      ST_FIN:  cmd_o.op = OP_FIN;
      ST_MA0:  cmd_o.op = OP_MUL_LL;
      ST_MA1:  cmd_o.op = OP_MUL_LH;
      ST_MA2:  cmd_o.op = OP_MUL_HL;
      ST_MB0: begin
        cmd_o.op    = OP_MUL_LL;
        cmd_o.sel_b = 1'b1;
      end
      ST_MB1: begin
        cmd_o.op    = OP_MUL_LH;
        cmd_o.sel_b = 1'b1;
      end
      ST_MB2: begin
        cmd_o.op    = OP_MUL_HL;
        cmd_o.sel_b = 1'b1;
      end
      ST_EMIT: if (status_i.out_free) cmd_o.op = OP_EMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/wordwise_fnv1a_avalanche_hash_top.sv @@
// Word-wise FNV-1a hash with a Murmur3 64-bit finaliser.
// item_i carries a span as 64-bit little-endian words (data_word, byte_count,
// last, absent); result_o carries one hash_value per span, or the plain offset
// basis for an item marked absent.
// Throughput: words that are not last are taken one per cycle while idle.
// A last word folds its n = 1..7 tail bytes, if any, one per cycle through the
// FNV step, then passes ST_FIN, the finaliser states and ST_EMIT, which loads
// the output register; only then is the next item taken. The finaliser uses a
// single 32x32 multiplier for two 64-bit products, in MA0..MA2 and MB0..MB2
// (low x low, low x high, high x low). An absent item goes straight to ST_EMIT.
// The result sits in an output register; while it waits to be taken the block
// keeps accepting words of the next span, and stops only when the next result
// is ready and the register is still full.
// Reset clears the running hash to the offset basis, the byte total to zero
// and drops any pending result.
module wordwise_fnv1a_avalanche_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  wfah_in_if.sink     item_i,
  wfah_out_if.source  result_o
);
  import wfah_pkg::*;

  cmd_t    cmd;
  status_t status;

  wfah_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wfah_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .data_word_i  (item_i.data_word),
    .byte_count_i (item_i.byte_count),
    .last_i       (item_i.last),
    .absent_i     (item_i.absent),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .hash_value_o (result_o.hash_value)
  );

endmodule
